// File: rtl/crlc_pkg.sv
// Package for the coefficient run-length coder: sizes, symbol codes and shared types.
// Depends on nothing; every rtl file imports it.
package crlc_pkg;

  // Coefficients per block and the width of the position counter
  localparam int BLOCK_COEFFS = 64;
  localparam int POS_W        = $clog2(BLOCK_COEFFS);

  localparam int COEF_W    = 16;
  localparam int BYTE_W    = 8;
  // Pending runs, symbol, up to three amplitude bytes, end byte
  localparam int BURST_MAX = 8;
  localparam int COUNT_W   = $clog2(BURST_MAX + 1);

  localparam logic [BYTE_W-1:0] RUN_SYMBOL  = 8'hF0;
  localparam logic [BYTE_W-1:0] END_SYMBOL  = 8'h00;
  localparam logic [2:0]        MAX_PENDING = 3'd3;
  localparam logic [3:0]        ZERO_WRAP   = 4'd15;

  // Running state of the coder between coefficients
  typedef struct packed {
    logic [3:0]       zero_count;
    logic [2:0]       pending_runs;
    logic [POS_W-1:0] position;
  } crlc_state_t;

  // All output bytes caused by one coefficient, first byte in slot 0
  typedef struct packed {
    logic [BURST_MAX-1:0][BYTE_W-1:0] bytes;
    logic [COUNT_W-1:0]               count;
    logic                             has_end;
  } crlc_burst_t;

endpackage

// File: rtl/crlc_encode.sv
// Combinational coder: one coefficient and the running state give a byte burst
// and the next state. Depends on crlc_pkg.
module crlc_encode
  import crlc_pkg::*;
(
  input  logic [COEF_W-1:0] coefficient,
  input  crlc_state_t       state,
  output crlc_state_t       state_next,
  output crlc_burst_t       burst
);

  logic              is_zero;
  logic              is_last;
  logic [COEF_W:0]   ext;
  logic [COEF_W:0]   mag;
  logic [4:0]        lead;
  logic [4:0]        size;
  logic [1:0]        nbytes;
  logic [BYTE_W-1:0] symbol;
  logic [BYTE_W-1:0] amp [3];
  logic [3:0]        p;
  logic [3:0]        sym_slot;
  logic [3:0]        end_slot;

  // Magnitude and size from the leading one
  always_comb begin
    is_zero = (coefficient == '0);
    is_last = (state.position == POS_W'(BLOCK_COEFFS - 1));
    ext     = {coefficient[COEF_W-1], coefficient};
    mag     = coefficient[COEF_W-1] ? (COEF_W+1)'(-ext) : ext;
    lead    = '0;
    for (int i = 0; i < COEF_W + 1; i++) begin
      if (mag[i]) lead = 5'(i);
    end
    size   = lead + 5'd2;
    nbytes = (size <= 5'd8) ? 2'd1 : ((size <= 5'd16) ? 2'd2 : 2'd3);
    symbol = {state.zero_count, size[3:0]};
    amp[0] = coefficient[7:0];
    amp[1] = coefficient[15:8];
    amp[2] = {BYTE_W{coefficient[COEF_W-1]}};
  end

  // Place pending runs, symbol, amplitude bytes and end byte into slots
  always_comb begin
    p        = {1'b0, state.pending_runs};
    sym_slot = is_zero ? 4'd0 : p;
    end_slot = is_zero ? 4'd0 : (p + 4'd1 + {2'b00, nbytes});
    burst.has_end = is_last;
    burst.count   = COUNT_W'(end_slot + {3'b000, is_last});
    for (int i = 0; i < BURST_MAX; i++) begin
      if (!is_zero && 4'(i) < p) begin
        burst.bytes[i] = RUN_SYMBOL;
      end else if (!is_zero && 4'(i) == sym_slot) begin
        burst.bytes[i] = symbol;
      end else if (!is_zero && 4'(i) < end_slot) begin
        burst.bytes[i] = amp[2'(4'(i) - p - 4'd1)];
      end else begin
        burst.bytes[i] = END_SYMBOL;
      end
    end
  end

  // Advance zero count, pending runs and block position
  always_comb begin
    state_next = state;
    if (is_zero) begin
      if (state.zero_count < ZERO_WRAP) begin
        state_next.zero_count = state.zero_count + 4'd1;
      end else begin
        state_next.zero_count = '0;
        if (state.pending_runs < MAX_PENDING) begin
          state_next.pending_runs = state.pending_runs + 3'd1;
        end
      end
    end else begin
      state_next.zero_count   = '0;
      state_next.pending_runs = '0;
    end
    state_next.position = state.position + POS_W'(1);
    if (is_last) begin
      state_next = '0;
    end
  end

endmodule

// File: rtl/crlc_emit.sv
// Burst register and byte serializer: holds one burst and sends it a byte per
// cycle on the output stream while m_axis_tready is high. Depends on crlc_pkg.
module crlc_emit
  import crlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  crlc_burst_t burst,
  output logic        ready,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] code_byte
  output logic        m_axis_tlast   // block_end
);

  logic [BYTE_W-1:0]  bytes [BURST_MAX];
  logic [COUNT_W-1:0] remaining;
  logic [COUNT_W-1:0] remaining_next;
  logic               has_end;
  logic               pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign ready         = (remaining == '0) || ((remaining == COUNT_W'(1)) && m_axis_tready);
  assign m_axis_tvalid = (remaining != '0);
  assign m_axis_tdata  = bytes[0];
  assign m_axis_tlast  = has_end && (remaining == COUNT_W'(1));

  // Count bytes left in the held burst
  always_comb begin
    remaining_next = remaining;
    if (load) begin
      remaining_next = burst.count;
    end else if (pop) begin
      remaining_next = remaining - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else begin
      remaining <= remaining_next;
    end
  end

  // Load a new burst or shift the held one down by a byte
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < BURST_MAX; i++) begin
        bytes[i] <= burst.bytes[i];
      end
      has_end <= burst.has_end;
    end else if (pop) begin
      for (int i = 0; i < BURST_MAX - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
    end
  end

  a_load_when_ready: assert property (@(posedge clk) disable iff (rst)
    load |-> ready) else $error("burst loaded while bytes still pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= COUNT_W'(BURST_MAX)) else $error("burst count out of range");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == END_SYMBOL))
    else $error("block end marked on a byte other than the end symbol");

endmodule

// File: rtl/coefficient_run_length_coder_top.sv
// Top level of the coefficient run-length coder: input register, coder state
// and the byte serializer. Depends on crlc_pkg, crlc_encode and crlc_emit.
//
//   port group   dir  tdata                  tlast
//   s_axis       in   [15:0] coefficient     -
//   m_axis       out  [7:0]  code_byte       block_end
//
// A coefficient that makes no byte leaves the burst register empty; while the
// serializer is empty the input register takes a new coefficient every cycle.
// A coefficient that makes n bytes (1 to 8) holds back the next one in the input
// register until the single-byte output port sends the last byte of its burst.
// Its first byte is valid once the burst register loads it from the input register.
// rst clears the block position, zero count, pending runs and all valid flags.
// A stall on m_axis holds the burst and, once the input register is full, s_axis.
module coefficient_run_length_coder_top
  import crlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] coefficient
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] code_byte
  output logic        m_axis_tlast   // block_end
);

  logic              in_valid;
  logic              in_valid_next;
  logic [COEF_W-1:0] in_coef;
  crlc_state_t       state;
  crlc_state_t       state_next;
  crlc_burst_t       burst;
  logic              emit_ready;
  logic              advance;
  logic              accept;

  assign advance       = in_valid && emit_ready;
  assign s_axis_tready = !in_valid || emit_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Hold the accepted coefficient until the serializer takes its burst
  always_comb begin
    in_valid_next = in_valid;
    if (accept) begin
      in_valid_next = 1'b1;
    end else if (advance) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      state    <= '0;
    end else begin
      in_valid <= in_valid_next;
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_coef <= s_axis_tdata;
    end
  end

  crlc_encode u_encode (
    .coefficient (in_coef),
    .state       (state),
    .state_next  (state_next),
    .burst       (burst)
  );

  crlc_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .burst         (burst),
    .ready         (emit_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    state.pending_runs <= MAX_PENDING) else $error("pending runs above limit");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !emit_ready) |=> (in_valid && $stable(in_coef)))
    else $error("held item lost while serializer busy");

endmodule

// File: sim/tb_coefficient_run_length_coder_top.sv
`timescale 1ns / 100ps
// Testbench for coefficient_run_length_coder_top: coefficients are streamed in whole blocks
// and every code byte is checked against a predicted byte stream. Depends on crlc_pkg.
module tb_coefficient_run_length_coder_top;
  import crlc_pkg::*;

  localparam int BLOCK_COUNT  = 5;
  localparam int ITEM_TOTAL   = BLOCK_COUNT * BLOCK_COEFFS;
  localparam int HOLDOFF_AT   = 40;
  localparam int HOLDOFF_LEN  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_t;

  typedef enum logic [1:0] {
    BK_RUNS,
    BK_ALL_ZERO,
    BK_LATE_LAST,
    BK_DENSE
  } block_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              last;
  } code_item_t;

  // Opening coefficients: extremes, 0xF0 amplitude bytes, size boundaries
  localparam logic [COEF_W-1:0] DIRECTED [16] = '{
    16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'hFFF0, 16'h00F0,
    16'hF0F0, 16'h0002, 16'hFFFE, 16'h007F, 16'hFF80, 16'h0080, 16'h4000, 16'hBFFF
  };
  localparam block_kind_t BLOCK_PLAN [BLOCK_COUNT] = '{
    BK_RUNS, BK_ALL_ZERO, BK_RUNS, BK_LATE_LAST, BK_DENSE
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [COEF_W-1:0]  s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]  m_axis_tdata;
  logic               m_axis_tlast;

  logic [COEF_W-1:0]  pending_coefs [$];
  code_item_t         expected_codes [$];
  code_item_t         oldest_code;
  int                 coefs_accepted = 0;
  int                 mismatches = 0;
  int                 holdoff_left = 0;
  logic               holdoff_done = 1'b0;

  // Predicted coder state
  logic [3:0]         zero_run = '0;
  logic [2:0]         held_runs = '0;
  int                 coef_index = 0;

  coefficient_run_length_coder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Idling phase follows progress through the coefficient stream
  function automatic idle_phase_t phase_of(int accepted);
    if (accepted < ITEM_TOTAL / 4) return PH_FREE;
    if (accepted < ITEM_TOTAL / 2) return PH_SEND_IDLE;
    if (accepted < 3 * ITEM_TOTAL / 4) return PH_RECV_STALL;
    return PH_BOTH;
  endfunction

  // Nonzero coefficient of random size and sign, with 0xF0 bytes and -32768 mixed in
  function automatic logic [COEF_W-1:0] random_coef();
    logic [COEF_W-1:0] mag;
    logic [7:0]        other;
    int                w;
    other = 8'($urandom);
    case ($urandom_range(19))
      0: return 16'h8000;
      1: return {other, 8'hF0};
      2: return {8'hF0, other};
      default: begin
        w   = $urandom_range(14);
        mag = 16'(1 << w) | (16'($urandom) & 16'((1 << w) - 1));
        return $urandom_range(1) ? 16'd0 - mag : mag;
      end
    endcase
  endfunction

  // Work out the code bytes that one coefficient causes
  task automatic predict_codes(input logic [COEF_W-1:0] coef);
    logic [31:0] ext;
    logic [16:0] mag;
    logic [4:0]  size;
    int          nbytes;
    if (coef == '0) begin
      if (zero_run < ZERO_WRAP) begin
        zero_run++;
      end else begin
        zero_run = '0;
        if (held_runs < MAX_PENDING) held_runs++;
      end
    end else begin
      ext  = {{16{coef[15]}}, coef};
      mag  = coef[15] ? 17'd0 - ext[16:0] : {1'b0, coef};
      size = 5'd2;
      for (int b = 1; b < 17; b++) begin
        if (mag[b]) size = 5'(b + 2);
      end
      nbytes = (size + 7) / 8;
      repeat (held_runs) expected_codes.push_back('{code: RUN_SYMBOL, last: 1'b0});
      held_runs = '0;
      expected_codes.push_back('{code: {zero_run, size[3:0]}, last: 1'b0});
      zero_run = '0;
      for (int k = 0; k < nbytes; k++) begin
        expected_codes.push_back('{code: ext[8*k +: 8], last: 1'b0});
      end
    end
    coef_index++;
    if (coef_index >= BLOCK_COEFFS) begin
      expected_codes.push_back('{code: END_SYMBOL, last: 1'b1});
      zero_run   = '0;
      held_runs  = '0;
      coef_index = 0;
    end
  endtask

  // Fill the coefficient queue: directed opening, then blocks of planned shapes
  task automatic fill_coefs();
    int          zeros_left;
    block_kind_t kind;
    zeros_left = 0;
    foreach (DIRECTED[i]) pending_coefs.push_back(DIRECTED[i]);
    for (int i = $size(DIRECTED); i < ITEM_TOTAL; i++) begin
      kind = BLOCK_PLAN[i / BLOCK_COEFFS];
      case (kind)
        BK_ALL_ZERO: pending_coefs.push_back('0);
        BK_LATE_LAST: begin
          // 63 zeros leave three pending runs and a full count before -32768
          pending_coefs.push_back((i % BLOCK_COEFFS == BLOCK_COEFFS - 1) ? 16'h8000 : '0);
        end
        BK_DENSE: pending_coefs.push_back(chance(25) ? '0 : random_coef());
        default: begin
          if (zeros_left > 0) begin
            pending_coefs.push_back('0);
            zeros_left--;
          end else begin
            pending_coefs.push_back(random_coef());
            zeros_left = chance(30) ? $urandom_range(40, 15) : $urandom_range(6);
          end
        end
      endcase
    end
  endtask

  // Driver: predict on each accepted coefficient, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_codes(s_axis_tdata);
        coefs_accepted <= coefs_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_coefs.size() != 0 && !chance(
            phase_of(coefs_accepted) == PH_SEND_IDLE ? 83 :
            phase_of(coefs_accepted) == PH_BOTH ? 8 : 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_coefs.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Hold off the output once for a long stretch so the coder backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && coefs_accepted >= HOLDOFF_AT) begin
      holdoff_left <= HOLDOFF_LEN;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Monitor: stall at random and check each accepted code byte against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (holdoff_left == 0) && !chance(
          phase_of(coefs_accepted) == PH_RECV_STALL ? 83 :
          phase_of(coefs_accepted) == PH_BOTH ? 8 : 0);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_codes.size() == 0) begin
          $error("code byte %02h with no prediction waiting", m_axis_tdata);
          mismatches <= mismatches + 1;
        end else begin
          oldest_code = expected_codes.pop_front();
          if (m_axis_tdata !== oldest_code.code) begin
            $error("code_byte: expected %02h, got %02h", oldest_code.code, m_axis_tdata);
            mismatches <= mismatches + 1;
          end else if (m_axis_tlast !== oldest_code.last) begin
            $error("block_end: expected %0b, got %0b", oldest_code.last, m_axis_tlast);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  // Run control: reset, wait for the stream to drain, report
  initial begin
    fill_coefs();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (coefs_accepted == ITEM_TOTAL);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up well past the slowest correct run
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: coefficient_run_length_coder_top.f
rtl/crlc_pkg.sv
rtl/crlc_encode.sv
rtl/crlc_emit.sv
rtl/coefficient_run_length_coder_top.sv
sim/tb_coefficient_run_length_coder_top.sv
